// ===== hw/rtl/lsi_pkg.sv =====
// Shared types, constants and rounding helpers for the line/sphere intersection block.
// No dependencies.
package lsi_pkg;

  localparam int unsigned FRAC_BITS = 16;  // fraction bits of coordinates, r2, a2, d2

  typedef enum logic [1:0] {
    STATUS_MISS  = 2'd0,
    STATUS_HIT   = 2'd1,
    STATUS_DEGEN = 2'd2
  } status_e;

  // per-item geometry carried down the pipe
  typedef struct packed {
    logic [2:0]        neg;   // direction sign per axis
    logic [2:0][32:0]  w;     // C - A, signed
    logic [2:0][31:0]  a;     // line start, signed
    logic [47:0]       r2;
    logic              degen;
  } geo_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    geo_t             geo;
  } pre_t;

  typedef struct packed {
    logic [2:0][29:0] mag;    // normalized direction magnitudes
    geo_t             geo;
  } norm_t;

  typedef struct packed {
    logic [2:0][30:0] q;      // |V| per axis, Q2.30
    logic [2:0]       vneg;
    logic [2:0][31:0] a;
    logic [36:0]      lpar;   // signed
    logic             hit;
    logic             degen;
  } hit_t;

  typedef struct packed {
    status_e          status;
    logic [2:0][31:0] near_p;
    logic [2:0][31:0] far_p;
  } result_t;

  // round(prod / 2^30) half away from zero, sign applied afterwards
  function automatic logic signed [38:0] rnd30(input logic [69:0] prod, input logic neg);
    logic [69:0]        s;
    logic signed [38:0] m;
    s = prod + (70'd1 << 29);
    m = {1'b0, s[67:30]};
    return neg ? -m : m;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    logic [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lsi_sqrt_cell.sv =====
// One step of a pipelined integer square root (two radicand bits per cell).
// Standalone; the chain of 32 cells yields floor(sqrt(x)) of a 64-bit radicand.
module lsi_sqrt_cell #(
  parameter int unsigned Step  = 0,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [63:0]      x_i,
  input  logic [63:0]      r_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [63:0]      x_o,
  output logic [63:0]      r_o,
  output logic [SideW-1:0] side_o
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Step);

  logic [63:0] trial;
  logic        take;
  logic [63:0] x_d, r_d;

  assign trial = r_i + Bit;
  assign take  = (x_i >= trial);
  assign x_d   = take ? (x_i - trial) : x_i;
  assign r_d   = take ? ((r_i >> 1) + Bit) : (r_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      r_o    <= r_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== hw/rtl/lsi_div_cell.sv =====
// One restoring-division step for three lanes sharing a divisor.
// Standalone; 31 cells give the 31-bit quotient of (mag << 30) / n.
module lsi_div_cell #(
  parameter int unsigned SideW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2:0][31:0]      t_i,
  input  logic [31:0]           n_i,
  input  logic [2:0][30:0]      q_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  valid_o,
  output logic [2:0][31:0]      t_o,
  output logic [31:0]           n_o,
  output logic [2:0][30:0]      q_o,
  output logic [SideW-1:0]      side_o
);

  logic [2:0]       ge;
  logic [2:0][31:0] rem;
  logic [2:0][31:0] t_d;
  logic [2:0][30:0] q_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ge[l]  = (t_i[l] >= n_i);
      rem[l] = ge[l] ? (t_i[l] - n_i) : t_i[l];
      t_d[l] = {rem[l][30:0], 1'b0};
      q_d[l] = {q_i[l][29:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o    <= t_d;
      n_o    <= n_i;
      q_o    <= q_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== hw/rtl/lsi_out_buf.sv =====
// Two-entry result buffer between the pipe and the output channel.
// Depends on lsi_pkg (result_t).
module lsi_out_buf
  import lsi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    space_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result buffer count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2) else $error("push into full result buffer");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i && count_q == 2'd1) |=> count_q == 2'd0)
    else $error("result buffer failed to drain");
`endif

endmodule

// ===== hw/rtl/line_sphere_intersection_top.sv =====
// Line/sphere intersection, signed Q16.16, one item per clock cycle while the pipe is not stalled.
// Each transfer carries a sphere (center, squared radius) and two line points A, B;
// one result transfer follows with status and the near/far hit points (saturated to
// 32 bits, zero on a miss, tangent or degenerate line). The pipe is a row of cells:
// 6 setup stages, 32 square-root cells for |B-A|, 31 divider cells for the unit
// direction, 8 stages for the projection and chord, 32 square-root cells for the
// half chord and 2 final stages, followed by the output buffer.
// The whole row advances together; it stalls only when the two-entry output buffer
// is full, so a new transfer is taken every cycle while one result is still waiting.
// Depends on lsi_pkg, lsi_sqrt_cell, lsi_div_cell and lsi_out_buf.
module line_sphere_intersection_top
  import lsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] center_x_i,
  input  logic [31:0] center_y_i,
  input  logic [31:0] center_z_i,
  input  logic [47:0] radius_squared_i,
  input  logic [31:0] start_x_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] start_z_i,
  input  logic [31:0] end_x_i,
  input  logic [31:0] end_y_i,
  input  logic [31:0] end_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] near_x_o,
  output logic [31:0] near_y_o,
  output logic [31:0] near_z_o,
  output logic [31:0] far_x_o,
  output logic [31:0] far_y_o,
  output logic [31:0] far_z_o
);

  localparam int unsigned NormW = $bits(norm_t);
  localparam int unsigned GeoW  = $bits(geo_t);
  localparam int unsigned HitW  = $bits(hit_t);

  logic en;  // global advance; pipe holds while the output buffer is full

  // ---------------- stage 1: differences ----------------
  logic [31:0]        c_in [3];
  logic [31:0]        a_in [3];
  logic [31:0]        b_in [3];
  logic signed [32:0] dd [3];
  logic signed [32:0] nd [3];
  pre_t               s1_d, s1_q;
  logic               s1_valid_q;

  assign c_in[0] = center_x_i;  assign c_in[1] = center_y_i;  assign c_in[2] = center_z_i;
  assign a_in[0] = start_x_i;   assign a_in[1] = start_y_i;   assign a_in[2] = start_z_i;
  assign b_in[0] = end_x_i;     assign b_in[1] = end_y_i;     assign b_in[2] = end_z_i;

  always_comb begin
    s1_d = '0;
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({b_in[i][31], b_in[i]}) - $signed({a_in[i][31], a_in[i]});
      nd[i] = -dd[i];
      s1_d.mag[i]     = dd[i][32] ? nd[i][31:0] : dd[i][31:0];
      s1_d.geo.neg[i] = dd[i][32];
      s1_d.geo.w[i]   = $signed({c_in[i][31], c_in[i]}) - $signed({a_in[i][31], a_in[i]});
      s1_d.geo.a[i]   = a_in[i];
    end
    s1_d.geo.r2    = radius_squared_i;
    s1_d.geo.degen = (dd[0] == '0) && (dd[1] == '0) && (dd[2] == '0);
  end

  // ---------------- stage 2: largest magnitude ----------------
  pre_t        s2_q;
  logic [31:0] s2_m_q, m01;
  logic        s2_valid_q;
  assign m01 = (s1_q.mag[0] > s1_q.mag[1]) ? s1_q.mag[0] : s1_q.mag[1];

  // ---------------- stage 3: leading one of the max ----------------
  pre_t       s3_q;
  logic [4:0] s3_p_q, p_d;
  logic       s3_valid_q;
  always_comb begin
    p_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (s2_m_q[i]) p_d = 5'(i);
    end
  end

  // ---------------- stage 4: normalize to [2^29, 2^30) ----------------
  norm_t       s4_q, s4_d;
  logic        s4_valid_q;
  logic [31:0] shv [3];
  always_comb begin
    s4_d.geo = s3_q.geo;
    for (int i = 0; i < 3; i++) begin
      if (s3_p_q >= 5'd30) begin
        shv[i] = s3_q.mag[i] >> (s3_p_q - 5'd29);  // truncating scale-down
      end else begin
        shv[i] = s3_q.mag[i] << (5'd29 - s3_p_q);
      end
      s4_d.mag[i] = shv[i][29:0];
    end
  end

  // ---------------- stage 5/6: |D|^2 ----------------
  norm_t            s5_q, s6_q;
  logic [2:0][59:0] s5_sq_q;
  logic [63:0]      s6_n2_q;
  logic             s5_valid_q, s6_valid_q;

  // ---------------- stages 7..: projection and chord ----------------
  geo_t             s7_geo_q, s8_geo_q, s9_geo_q, s10_geo_q, s11_geo_q, s12_geo_q, s13_geo_q;
  logic [2:0][30:0] s7_vq_q, s8_vq_q, s9_vq_q, s10_vq_q, s11_vq_q, s12_vq_q, s13_vq_q;
  logic [2:0][63:0] s7_prod_q;
  logic [2:0]       s7_pn_q, s9_pn_q;
  logic [36:0]      s8_lpar_q, s9_lpar_q, s10_lpar_q, s11_lpar_q, s12_lpar_q, s13_lpar_q;
  logic [2:0][66:0] s9_prod_q;
  logic [2:0][35:0] s10_pabs_q;
  logic [2:0][35:0] s11_hh_q, s11_hl_q, s11_ll_q;
  logic [2:0][71:0] s12_psq_q;
  logic [57:0]      s13_a2_q;
  hit_t             s14_q;
  logic [63:0]      s14_rad_q;
  logic s7_valid_q, s8_valid_q, s9_valid_q, s10_valid_q, s11_valid_q, s12_valid_q;
  logic s13_valid_q, s14_valid_q;

  // first root chain: n = isqrt(|D|^2)
  logic              sa_valid [33];
  logic [63:0]       sa_x [33];
  logic [63:0]       sa_r [33];
  logic [NormW-1:0]  sa_side [33];
  norm_t             sa_out;

  assign sa_valid[0] = s6_valid_q;
  assign sa_x[0]     = s6_n2_q;
  assign sa_r[0]     = '0;
  assign sa_side[0]  = s6_q;
  assign sa_out      = norm_t'(sa_side[32]);

  for (genvar j = 0; j < 32; j++) begin : g_sqrt_a
    lsi_sqrt_cell #(.Step(j), .SideW(NormW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sa_valid[j]), .x_i(sa_x[j]), .r_i(sa_r[j]), .side_i(sa_side[j]),
      .valid_o(sa_valid[j+1]), .x_o(sa_x[j+1]), .r_o(sa_r[j+1]), .side_o(sa_side[j+1])
    );
  end

  // divider chain: |V_i| = (mag_i << 30) / n
  logic             dv_valid [32];
  logic [2:0][31:0] dv_t [32];
  logic [31:0]      dv_n [32];
  logic [2:0][30:0] dv_q [32];
  logic [GeoW-1:0]  dv_side [32];
  geo_t             dv_out;

  assign dv_valid[0] = sa_valid[32];
  assign dv_n[0]     = sa_r[32][31:0];
  assign dv_q[0]     = '0;
  assign dv_side[0]  = sa_out.geo;
  assign dv_out      = geo_t'(dv_side[31]);
  for (genvar l = 0; l < 3; l++) begin : g_t0
    assign dv_t[0][l] = {2'b00, sa_out.mag[l]};
  end

  for (genvar j = 0; j < 31; j++) begin : g_div
    lsi_div_cell #(.SideW(GeoW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_valid[j]), .t_i(dv_t[j]), .n_i(dv_n[j]), .q_i(dv_q[j]),
      .side_i(dv_side[j]),
      .valid_o(dv_valid[j+1]), .t_o(dv_t[j+1]), .n_o(dv_n[j+1]), .q_o(dv_q[j+1]),
      .side_o(dv_side[j+1])
    );
  end

  // combinational helpers for the projection stages
  logic [2:0][32:0]   wabs;
  logic signed [38:0] lsum;
  logic [35:0]        labs;
  logic signed [38:0] pw [3];
  logic signed [36:0] pv [3];
  logic [73:0]        psum;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      wabs[l] = dv_out.w[l][32] ? (33'd0 - dv_out.w[l]) : dv_out.w[l];
    end
    lsum = rnd30(70'(s7_prod_q[0]), s7_pn_q[0]) + rnd30(70'(s7_prod_q[1]), s7_pn_q[1])
         + rnd30(70'(s7_prod_q[2]), s7_pn_q[2]);
    labs = s8_lpar_q[36] ? 36'(37'd0 - s8_lpar_q) : s8_lpar_q[35:0];
    for (int l = 0; l < 3; l++) begin
      pw[l] = $signed({{6{s9_geo_q.w[l][32]}}, s9_geo_q.w[l]})
            - rnd30(70'(s9_prod_q[l]), s9_pn_q[l]);
      pv[l] = pw[l][36:0];
    end
    psum = 74'(s12_psq_q[0]) + 74'(s12_psq_q[1]) + 74'(s12_psq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      s2_q   <= s1_q;
      s2_m_q <= (m01 > s1_q.mag[2]) ? m01 : s1_q.mag[2];
      s3_q   <= s2_q;
      s3_p_q <= p_d;
      s4_q   <= s4_d;
      s5_q   <= s4_q;
      for (int l = 0; l < 3; l++) s5_sq_q[l] <= s4_q.mag[l] * s4_q.mag[l];
      s6_q    <= s5_q;
      s6_n2_q <= 64'(s5_sq_q[0]) + 64'(s5_sq_q[1]) + 64'(s5_sq_q[2]);
      // V.W per axis
      s7_geo_q <= dv_out;
      s7_vq_q  <= dv_q[31];
      for (int l = 0; l < 3; l++) begin
        s7_prod_q[l] <= 64'(dv_q[31][l]) * 64'(wabs[l]);
        s7_pn_q[l]   <= dv_out.neg[l] ^ dv_out.w[l][32];
      end
      s8_geo_q  <= s7_geo_q;
      s8_vq_q   <= s7_vq_q;
      s8_lpar_q <= lsum[36:0];
      // V * L
      s9_geo_q  <= s8_geo_q;
      s9_vq_q   <= s8_vq_q;
      s9_lpar_q <= s8_lpar_q;
      for (int l = 0; l < 3; l++) begin
        s9_prod_q[l] <= 67'(s8_vq_q[l]) * 67'(labs);
        s9_pn_q[l]   <= s8_geo_q.neg[l] ^ s8_lpar_q[36];
      end
      // perpendicular part P = W - V*L
      s10_geo_q  <= s9_geo_q;
      s10_vq_q   <= s9_vq_q;
      s10_lpar_q <= s9_lpar_q;
      for (int l = 0; l < 3; l++) begin
        s10_pabs_q[l] <= pv[l][36] ? 36'(37'd0 - pv[l]) : pv[l][35:0];
      end
      // |P_i|^2 from 18-bit halves
      s11_geo_q  <= s10_geo_q;
      s11_vq_q   <= s10_vq_q;
      s11_lpar_q <= s10_lpar_q;
      for (int l = 0; l < 3; l++) begin
        s11_hh_q[l] <= s10_pabs_q[l][35:18] * s10_pabs_q[l][35:18];
        s11_hl_q[l] <= s10_pabs_q[l][35:18] * s10_pabs_q[l][17:0];
        s11_ll_q[l] <= s10_pabs_q[l][17:0] * s10_pabs_q[l][17:0];
      end
      s12_geo_q  <= s11_geo_q;
      s12_vq_q   <= s11_vq_q;
      s12_lpar_q <= s11_lpar_q;
      for (int l = 0; l < 3; l++) begin
        s12_psq_q[l] <= (72'(s11_hh_q[l]) << 36) + (72'(s11_hl_q[l]) << 19)
                      + 72'(s11_ll_q[l]);
      end
      s13_geo_q  <= s12_geo_q;
      s13_vq_q   <= s12_vq_q;
      s13_lpar_q <= s12_lpar_q;
      s13_a2_q   <= psum[FRAC_BITS +: 58];
      // chord: d2 = r2 - a2, hit only when d2 > 0
      s14_q.q     <= s13_vq_q;
      s14_q.vneg  <= s13_geo_q.neg;
      s14_q.a     <= s13_geo_q.a;
      s14_q.lpar  <= s13_lpar_q;
      s14_q.degen <= s13_geo_q.degen;
      s14_q.hit   <= !s13_geo_q.degen && (58'(s13_geo_q.r2) > s13_a2_q);
      s14_rad_q   <= 64'(s13_geo_q.r2 - s13_a2_q[47:0]) << FRAC_BITS;
    end
  end

  // second root chain: s = isqrt(d2 << FRAC_BITS); d2 < 2^48 so no range reduction
  logic             sb_valid [33];
  logic [63:0]      sb_x [33];
  logic [63:0]      sb_r [33];
  logic [HitW-1:0]  sb_side [33];
  hit_t             sb_out;

  assign sb_valid[0] = s14_valid_q;
  assign sb_x[0]     = s14_rad_q;
  assign sb_r[0]     = '0;
  assign sb_side[0]  = s14_q;
  assign sb_out      = hit_t'(sb_side[32]);

  for (genvar j = 0; j < 32; j++) begin : g_sqrt_b
    lsi_sqrt_cell #(.Step(j), .SideW(HitW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sb_valid[j]), .x_i(sb_x[j]), .r_i(sb_r[j]), .side_i(sb_side[j]),
      .valid_o(sb_valid[j+1]), .x_o(sb_x[j+1]), .r_o(sb_r[j+1]), .side_o(sb_side[j+1])
    );
  end

  // ---------------- final stages: line parameters and points ----------------
  hit_t               s15_q, s16_q;
  logic signed [37:0] s15_tn_q, s15_tf_q;
  logic [2:0][67:0]   s16_pn_q, s16_pf_q;
  logic [2:0]         s16_sn_q, s16_sf_q;
  logic               s15_valid_q, s16_valid_q;
  logic [36:0]        tn_abs, tf_abs;
  result_t            res;
  logic signed [39:0] cn [3];
  logic signed [39:0] cf [3];

  assign tn_abs = s15_tn_q[37] ? 37'(38'sd0 - s15_tn_q) : s15_tn_q[36:0];
  assign tf_abs = s15_tf_q[37] ? 37'(38'sd0 - s15_tf_q) : s15_tf_q[36:0];

  always_comb begin
    res = '0;
    for (int l = 0; l < 3; l++) begin
      cn[l] = $signed({{8{s16_q.a[l][31]}}, s16_q.a[l]})
            + 40'(rnd30(70'(s16_pn_q[l]), s16_sn_q[l]));
      cf[l] = $signed({{8{s16_q.a[l][31]}}, s16_q.a[l]})
            + 40'(rnd30(70'(s16_pf_q[l]), s16_sf_q[l]));
    end
    if (s16_q.degen) begin
      res.status = STATUS_DEGEN;
    end else if (s16_q.hit) begin
      res.status = STATUS_HIT;
      for (int l = 0; l < 3; l++) begin
        res.near_p[l] = sat32(cn[l]);
        res.far_p[l]  = sat32(cf[l]);
      end
    end else begin
      res.status = STATUS_MISS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s15_q    <= sb_out;
      s15_tn_q <= $signed({sb_out.lpar[36], sb_out.lpar}) - $signed({6'd0, sb_r[32][31:0]});
      s15_tf_q <= $signed({sb_out.lpar[36], sb_out.lpar}) + $signed({6'd0, sb_r[32][31:0]});
      s16_q    <= s15_q;
      for (int l = 0; l < 3; l++) begin
        s16_pn_q[l] <= 68'(s15_q.q[l]) * 68'(tn_abs);
        s16_pf_q[l] <= 68'(s15_q.q[l]) * 68'(tf_abs);
        s16_sn_q[l] <= s15_q.vneg[l] ^ s15_tn_q[37];
        s16_sf_q[l] <= s15_q.vneg[l] ^ s15_tf_q[37];
      end
    end
  end

  // valid bits of the stages local to this module
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;  s2_valid_q  <= 1'b0;  s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;  s5_valid_q  <= 1'b0;  s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;  s8_valid_q  <= 1'b0;  s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;  s11_valid_q <= 1'b0;  s12_valid_q <= 1'b0;
      s13_valid_q <= 1'b0;  s14_valid_q <= 1'b0;  s15_valid_q <= 1'b0;
      s16_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= dv_valid[31];
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
      s11_valid_q <= s10_valid_q;
      s12_valid_q <= s11_valid_q;
      s13_valid_q <= s12_valid_q;
      s14_valid_q <= s13_valid_q;
      s15_valid_q <= sb_valid[32];
      s16_valid_q <= s15_valid_q;
    end
  end

  // ---------------- output buffer ----------------
  result_t out_data;

  lsi_out_buf u_out_buf (
    .clk_i,
    .rst_ni,
    .push_i (s16_valid_q && en),
    .data_i (res),
    .ready_i(out_ready_i),
    .valid_o(out_valid_o),
    .data_o (out_data),
    .space_o(en)
  );

  assign in_ready_o = en;
  assign status_o   = out_data.status;
  assign near_x_o   = out_data.near_p[0];
  assign near_y_o   = out_data.near_p[1];
  assign near_z_o   = out_data.near_p[2];
  assign far_x_o    = out_data.far_p[0];
  assign far_y_o    = out_data.far_p[1];
  assign far_z_o    = out_data.far_p[2];

endmodule
